### rtl/jse_pkg.sv
// Shared types, constants and helpers for the JSON string escape encoder.
`default_nettype none
package jse_pkg;

	localparam int QDEPTH = 4;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = PTR_W + 1;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	// One queued request: an error result or one or two UTF-16 units.
	typedef struct packed {
		logic        err;
		logic        last;
		logic        pair;
		logic [15:0] unit0;
		logic [15:0] unit1;
	} job_t;

	// Write side of the request queue.
	typedef struct packed {
		logic push;
		job_t job;
	} q_wr_t;

	// Read side of the request queue.
	typedef struct packed {
		logic pop;
	} q_rd_t;

	// Upper-case hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'b0, n};
		end else begin
			r = 8'h37 + {4'b0, n};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/jse_in_if.sv
// Input channel: one UTF-8 byte per request.
`default_nettype none
interface jse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_last;

	modport source(output valid, output in_byte, output string_last, input ready);
	modport sink(input valid, input in_byte, input string_last, output ready);
endinterface
`default_nettype wire

### rtl/jse_out_if.sv
// Output channel: one byte of escaped JSON text per request.
`default_nettype none
interface jse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       string_end;
	logic       bad_utf8;

	modport source(output valid, output out_byte, output run_end, output string_end,
		output bad_utf8, input ready);
	modport sink(input valid, input out_byte, input run_end, input string_end,
		input bad_utf8, output ready);
endinterface
`default_nettype wire

### rtl/jse_front.sv
// Front end: strict UTF-8 decode into UTF-16 units or an error request.
`default_nettype none
module jse_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	jse_in_if.sink             src,
	input  wire logic          q_full,
	output jse_pkg::q_wr_t     q_wr
);

	logic [1:0]  pend_q;
	logic [20:0] partial_q;
	logic [7:0]  lead_q;
	logic        disc_q;

	logic [1:0]  pend_next;
	logic [20:0] cp_next;
	logic [7:0]  lead_next;
	logic [20:0] cp_emit;
	logic [20:0] cp_off;
	logic [7:0]  b;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic        last;
	logic        err;
	logic        emit;
	logic        pair;
	logic        accept;

	assign src.ready = !q_full;
	assign accept    = src.valid && src.ready;

	always_comb begin
		b         = src.in_byte;
		last      = src.string_last;
		err       = 1'b0;
		emit      = 1'b0;
		pend_next = pend_q;
		cp_next   = partial_q;
		lead_next = lead_q;
		cp_emit   = '0;
		lo        = 8'h80;
		hi        = 8'hBF;
		if (pend_q == 2'd0) begin
			if (!b[7]) begin
				emit    = 1'b1;
				cp_emit = {13'b0, b};
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				pend_next = 2'd1;
				cp_next   = {16'b0, b[4:0]};
				lead_next = b;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				pend_next = 2'd2;
				cp_next   = {17'b0, b[3:0]};
				lead_next = b;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				pend_next = 2'd3;
				cp_next   = {18'b0, b[2:0]};
				lead_next = b;
			end else begin
				err = 1'b1;
			end
		end else begin
			// narrow the first continuation after leads with overlong or range limits
			if (lead_q == 8'hE0) begin
				lo = 8'hA0;
			end else if (lead_q == 8'hED) begin
				hi = 8'h9F;
			end else if (lead_q == 8'hF0) begin
				lo = 8'h90;
			end else if (lead_q == 8'hF4) begin
				hi = 8'h8F;
			end
			if (b < lo || b > hi) begin
				err = 1'b1;
			end else begin
				lead_next = 8'h00;
				cp_next   = {partial_q[14:0], b[5:0]};
				pend_next = pend_q - 2'd1;
				if (pend_next == 2'd0) begin
					emit    = 1'b1;
					cp_emit = cp_next;
					cp_next = '0;
				end
			end
		end
		if (!err && last && pend_next != 2'd0) begin
			err = 1'b1;
		end
		if (err || last) begin
			pend_next = 2'd0;
			cp_next   = '0;
			lead_next = 8'h00;
		end
	end

	assign cp_off = cp_emit - 21'h010000;
	assign pair   = |cp_emit[20:16];

	always_comb begin
		q_wr.push      = accept && !disc_q && (emit || err);
		q_wr.job.err   = err;
		q_wr.job.last  = last;
		q_wr.job.pair  = !err && pair;
		q_wr.job.unit0 = pair ? {6'b110110, cp_off[19:10]} : cp_emit[15:0];
		q_wr.job.unit1 = {6'b110111, cp_off[9:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 2'd0;
			partial_q <= '0;
			lead_q    <= 8'h00;
			disc_q    <= 1'b0;
		end else if (accept) begin
			if (disc_q) begin
				// drop bytes until the end of the string
				if (last) begin
					pend_q    <= 2'd0;
					partial_q <= '0;
					lead_q    <= 8'h00;
					disc_q    <= 1'b0;
				end
			end else begin
				pend_q    <= pend_next;
				partial_q <= cp_next;
				lead_q    <= lead_next;
				disc_q    <= err && !last;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/jse_fifo.sv
// Short request queue between the decoder and the byte expander.
`default_nettype none
module jse_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jse_pkg::q_wr_t  q_wr,
	input  wire jse_pkg::q_rd_t  q_rd,
	output logic                 full,
	output logic                 head_valid,
	output jse_pkg::job_t        head
);

	jse_pkg::job_t                mem_q [jse_pkg::QDEPTH];
	logic [jse_pkg::PTR_W-1:0]    wr_ptr_q;
	logic [jse_pkg::PTR_W-1:0]    rd_ptr_q;
	logic [jse_pkg::CNT_W-1:0]    count_q;

	assign full       = count_q == jse_pkg::CNT_W'(jse_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_rd.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (q_wr.push && !q_rd.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!q_wr.push && q_rd.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !q_wr.push || q_rd.pop)
		else $error("request queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd.pop |-> head_valid)
		else $error("request queue underflow");
`endif

endmodule
`default_nettype wire

### rtl/jse_back.sv
// Back end: expands each queued request into escaped JSON bytes.
`default_nettype none
module jse_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire jse_pkg::job_t  head,
	output jse_pkg::q_rd_t      q_rd,
	jse_out_if.source           dst
);

	logic        idx_q;
	logic [2:0]  pos_q;
	logic        valid_q;
	logic [7:0]  out_byte_q;
	logic        run_end_q;
	logic        string_end_q;
	logic        bad_q;

	logic [15:0] u;
	logic [7:0]  esc_ch;
	logic        esc_hit;
	logic        raw;
	logic [2:0]  last_pos;
	logic [7:0]  nxt_byte;
	logic        fin_unit;
	logic        fin_job;
	logic        advance;

	always_comb begin
		u       = idx_q ? head.unit1 : head.unit0;
		esc_hit = 1'b1;
		case (u)
			16'h005C: esc_ch = 8'h5C;
			16'h0022: esc_ch = 8'h22;
			16'h002F: esc_ch = 8'h2F;
			16'h0009: esc_ch = 8'h74;
			16'h0008: esc_ch = 8'h62;
			16'h000C: esc_ch = 8'h66;
			16'h000A: esc_ch = 8'h6E;
			16'h000D: esc_ch = 8'h72;
			default: begin
				esc_ch  = 8'h00;
				esc_hit = 1'b0;
			end
		endcase
		raw = !esc_hit && u > 16'h001F && u < 16'h0080;

		if (esc_hit) begin
			last_pos = 3'd1;
			nxt_byte = (pos_q == 3'd0) ? jse_pkg::CH_BSLASH : esc_ch;
		end else if (raw) begin
			last_pos = 3'd0;
			nxt_byte = u[7:0];
		end else begin
			last_pos = 3'd5;
			case (pos_q)
				3'd0:    nxt_byte = jse_pkg::CH_BSLASH;
				3'd1:    nxt_byte = jse_pkg::CH_U;
				3'd2:    nxt_byte = jse_pkg::hex_char(u[15:12]);
				3'd3:    nxt_byte = jse_pkg::hex_char(u[11:8]);
				3'd4:    nxt_byte = jse_pkg::hex_char(u[7:4]);
				3'd5:    nxt_byte = jse_pkg::hex_char(u[3:0]);
				default: nxt_byte = 8'h00;
			endcase
		end

		fin_unit = pos_q == last_pos;
		fin_job  = fin_unit && (idx_q == head.pair);
		if (head.err) begin
			nxt_byte = 8'h00;
			fin_unit = 1'b1;
			fin_job  = 1'b1;
		end
	end

	assign advance   = head_valid && (!valid_q || dst.ready);
	assign q_rd.pop  = advance && fin_job;

	assign dst.valid      = valid_q;
	assign dst.out_byte   = out_byte_q;
	assign dst.run_end    = run_end_q;
	assign dst.string_end = string_end_q;
	assign dst.bad_utf8   = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
			pos_q   <= 3'd0;
		end else begin
			if (!valid_q || dst.ready) begin
				valid_q <= head_valid;
			end
			if (advance) begin
				if (fin_job) begin
					idx_q <= 1'b0;
					pos_q <= 3'd0;
				end else if (fin_unit) begin
					idx_q <= 1'b1;
					pos_q <= 3'd0;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q   <= nxt_byte;
			run_end_q    <= fin_job;
			string_end_q <= fin_job && head.last;
			bad_q        <= head.err;
		end
	end

`ifndef ASSERT_OFF
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && bad_q |-> out_byte_q == 8'h00 && run_end_q)
		else $error("error result must be a single zero byte");
	a_end_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && string_end_q |-> run_end_q)
		else $error("string end without run end");
	a_second_unit: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && idx_q |-> head.pair && !head.err)
		else $error("second unit selected for a single-unit request");
`endif

endmodule
`default_nettype wire

### rtl/json_string_escape_encoder.sv
// Top level of the JSON string escape encoder.
//
//  channel  role    payload
//  -------  ------  ---------------------------------------------
//  src      sink    in_byte[7:0], string_last
//  dst      source  out_byte[7:0], run_end, string_end, bad_utf8
//
// The decoder takes one byte per cycle while the 4-entry request queue has room.
// The expander sends one result byte per cycle while it has a request and dst is
// ready: 1 for raw text, 2 for short escapes, 6 per \uXXXX unit (12 for a
// surrogate pair), 1 for an error. Sustained rate is set by the expander's
// output byte count. Reset (arst_n low) clears decoder state, the queue and
// dst.valid. A stalled dst holds its byte; src stalls only once the queue fills.
`default_nettype none
module json_string_escape_encoder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jse_in_if.sink     src,
	jse_out_if.source  dst
);

	jse_pkg::q_wr_t q_wr;
	jse_pkg::q_rd_t q_rd;
	jse_pkg::job_t  head;
	logic           q_full;
	logic           head_valid;

	jse_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	jse_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_wr       (q_wr),
		.q_rd       (q_rd),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.q_rd       (q_rd),
		.dst        (dst)
	);

endmodule
`default_nettype wire

### verif/tb_json_string_escape_encoder.sv
// Self-checking testbench for the JSON string escape encoder: directed rows, then random strings.
module tb_json_string_escape_encoder;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 7;
	localparam int QUIET_LIMIT  = 2000;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX   = 10;
	localparam int PHASE_ITEMS  = 110;

	typedef struct packed {
		logic [7:0] text;
		logic       run_end;
		logic       string_end;
		logic       bad;
	} text_res_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
		logic       known;
		text_res_t  res;
	} seed_row_t;

	localparam text_res_t NO_RES  = '0;
	localparam text_res_t BAD_MID = '{8'h00, 1'b1, 1'b0, 1'b1};
	localparam text_res_t BAD_END = '{8'h00, 1'b1, 1'b1, 1'b1};

	localparam int DIRECTED_ROWS = 25;
	localparam seed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}}, // plain letter right after reset
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h7F, 1'b0, 1'b0, NO_RES},
		'{8'h5C, 1'b0, 1'b0, NO_RES},
		'{8'h22, 1'b0, 1'b0, NO_RES},
		'{8'h2F, 1'b0, 1'b0, NO_RES},
		'{8'h09, 1'b0, 1'b0, NO_RES},
		'{8'h08, 1'b0, 1'b0, NO_RES},
		'{8'h0C, 1'b0, 1'b0, NO_RES},
		'{8'h0A, 1'b0, 1'b0, NO_RES},
		'{8'h0D, 1'b0, 1'b0, NO_RES},
		'{8'h01, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b1, BAD_END},                    // invalid lead on the last byte
		'{8'h80, 1'b0, 1'b1, BAD_MID},                    // stray continuation starts discarding
		'{8'hC2, 1'b0, 1'b0, NO_RES},
		'{8'h41, 1'b1, 1'b0, NO_RES},
		'{8'hF4, 1'b0, 1'b0, NO_RES},                     // highest code point, surrogate pair
		'{8'h8F, 1'b0, 1'b0, NO_RES},
		'{8'hBF, 1'b0, 1'b0, NO_RES},
		'{8'hBF, 1'b1, 1'b0, NO_RES},
		'{8'hE0, 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b1, BAD_END},                    // overlong three-byte form
		'{8'hC3, 1'b1, 1'b1, BAD_END},                    // string cut off after a lead
		'{8'hC2, 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES}
	};

	logic clk;
	logic arst_n;

	jse_in_if  src_ch();
	jse_out_if dst_ch();

	json_string_escape_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_ch),
		.dst    (dst_ch)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Decoder state of the predictor.
	logic [1:0]  dec_pending = '0;
	logic [20:0] dec_cp      = '0;
	logic [7:0]  dec_lead    = '0;
	logic        dec_drop    = 1'b0;

	text_res_t  scratch[$];
	text_res_t  expected_text[$];
	logic [7:0] str_bytes[$];

	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;
	int   items_sent   = 0;
	int   mismatches   = 0;
	int   quiet_cycles = 0;
	logic long_hold    = 1'b0;
	logic row_known    = 1'b0;
	text_res_t row_res = '0;

	function automatic void put_char(input logic [7:0] c);
		scratch.push_back('{c, 1'b0, 1'b0, 1'b0});
	endfunction

	function automatic void put_unit(input logic [15:0] u);
		logic [7:0] esc;
		logic [3:0] nib;
		int k;
		esc = 8'h00;
		case (u)
			16'h005C: esc = jse_pkg::CH_BSLASH;
			16'h0022: esc = 8'h22;
			16'h002F: esc = "/";
			16'h0009: esc = "t";
			16'h0008: esc = "b";
			16'h000C: esc = "f";
			16'h000A: esc = "n";
			16'h000D: esc = "r";
			default: esc = 8'h00;
		endcase
		if (esc != 8'h00) begin
			put_char(jse_pkg::CH_BSLASH);
			put_char(esc);
		end else if (u > 16'h001F && u < 16'h0080) begin
			put_char(u[7:0]);
		end else begin
			put_char(jse_pkg::CH_BSLASH);
			put_char(jse_pkg::CH_U);
			for (k = 3; k >= 0; k--) begin
				nib = u[4*k +: 4];
				put_char(nib < 4'd10 ? 8'h30 + 8'(nib) : 8'h37 + 8'(nib));
			end
		end
	endfunction

	function automatic void put_code_point(input logic [20:0] cp);
		logic [20:0] v;
		if (cp > 21'h00FFFF) begin
			v = cp - 21'h010000;
			put_unit(16'hD800 | {6'b0, v[19:10]});
			put_unit(16'hDC00 | {6'b0, v[9:0]});
		end else begin
			put_unit(cp[15:0]);
		end
	endfunction

	function automatic void clear_decoder();
		dec_pending = '0;
		dec_cp      = '0;
		dec_lead    = '0;
	endfunction

	// Escaped text caused by one accepted byte, left in scratch.
	function automatic void escape_utf8_byte(input logic [7:0] b, input logic last);
		logic       err;
		logic [7:0] lo;
		logic [7:0] hi;
		text_res_t  tail;
		err = 1'b0;
		scratch.delete();
		if (dec_drop) begin
			if (last) begin
				clear_decoder();
				dec_drop = 1'b0;
			end
			return;
		end
		if (dec_pending == 2'd0) begin
			if (b < 8'h80) begin
				put_unit({8'h00, b});
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				dec_pending = 2'd1;
				dec_cp      = {16'b0, b[4:0]};
				dec_lead    = b;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				dec_pending = 2'd2;
				dec_cp      = {17'b0, b[3:0]};
				dec_lead    = b;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				dec_pending = 2'd3;
				dec_cp      = {18'b0, b[2:0]};
				dec_lead    = b;
			end else begin
				err = 1'b1;
			end
		end else begin
			lo = 8'h80;
			hi = 8'hBF;
			case (dec_lead)
				8'hE0: lo = 8'hA0;
				8'hED: hi = 8'h9F;
				8'hF0: lo = 8'h90;
				8'hF4: hi = 8'h8F;
				default: ;
			endcase
			if (b < lo || b > hi) begin
				err = 1'b1;
			end else begin
				dec_lead    = '0;
				dec_cp      = {dec_cp[14:0], b[5:0]};
				dec_pending = dec_pending - 2'd1;
				if (dec_pending == 2'd0) begin
					put_code_point(dec_cp);
					dec_cp = '0;
				end
			end
		end
		if (!err && last && dec_pending != 2'd0)
			err = 1'b1;
		if (err) begin
			scratch.delete();
			scratch.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
			clear_decoder();
			dec_drop = !last;
		end
		if (last)
			clear_decoder();
		if (scratch.size() != 0) begin
			tail = scratch.pop_back();
			tail.run_end    = 1'b1;
			tail.string_end = last;
			scratch.push_back(tail);
		end
	endfunction

	function automatic int unsigned pick_code_point();
		int unsigned corners [14] = '{32'h80, 32'h7FF, 32'h800, 32'hFFF, 32'h1000, 32'hD7FF,
			32'hE000, 32'hFFFF, 32'h10000, 32'h3FFFF, 32'h40000, 32'hFFFFF, 32'h100000,
			32'h10FFFF};
		int unsigned specials [12] = '{32'h5C, 32'h22, 32'h2F, 32'h09, 32'h08, 32'h0C,
			32'h0A, 32'h0D, 32'h1F, 32'h20, 32'h7E, 32'h7F};
		int unsigned cp;
		case ($urandom_range(0, 9))
			0: cp = $urandom_range(0, 127);
			1: cp = specials[$urandom_range(0, 11)];
			2: cp = $urandom_range(32, 126);
			3, 4: cp = $urandom_range(32'h80, 32'h7FF);
			5, 6: begin
				cp = $urandom_range(32'h800, 32'hFFFF);
				// step out of the surrogate range
				if (cp >= 32'hD800 && cp <= 32'hDFFF)
					cp = cp ^ 32'h2000;
			end
			8: cp = $urandom_range(32'h10000, 32'h10FFFF);
			default: cp = corners[$urandom_range(0, 13)];
		endcase
		return cp;
	endfunction

	function automatic void append_code_point(input int unsigned cp);
		if (cp < 32'h80) begin
			str_bytes.push_back(8'(cp));
		end else if (cp < 32'h800) begin
			str_bytes.push_back(8'hC0 | 8'(cp >> 6));
			str_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
		end else if (cp < 32'h10000) begin
			str_bytes.push_back(8'hE0 | 8'(cp >> 12));
			str_bytes.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
			str_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
		end else begin
			str_bytes.push_back(8'hF0 | 8'(cp >> 18));
			str_bytes.push_back(8'h80 | 8'((cp >> 12) & 32'h3F));
			str_bytes.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
			str_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
		end
	endfunction

	// Mostly well-formed strings; the rest broken sequences or plain noise.
	function automatic void build_string();
		int kind;
		int n;
		int i;
		logic [7:0] lead;
		str_bytes.delete();
		n = $urandom_range(1, 8);
		for (i = 0; i < n; i++)
			append_code_point(pick_code_point());
		kind = $urandom_range(0, 99);
		if (kind >= 90) begin
			str_bytes.delete();
			n = $urandom_range(1, 8);
			for (i = 0; i < n; i++)
				str_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (kind >= 70) begin
			case ($urandom_range(0, 3))
				0: begin
					// end the string inside a sequence
					lead = 8'($urandom_range(8'hC2, 8'hF4));
					str_bytes.push_back(lead);
					if (lead >= 8'hE0 && $urandom_range(0, 1) == 1)
						str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
				end
				1: begin
					case ($urandom_range(0, 3))
						0: begin
							str_bytes.push_back(8'hE0);
							str_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
						end
						1: begin
							str_bytes.push_back(8'hED);
							str_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
						end
						2: begin
							str_bytes.push_back(8'hF0);
							str_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
						end
						default: begin
							str_bytes.push_back(8'hF4);
							str_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
						end
					endcase
					append_code_point(pick_code_point());
				end
				2: str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
				default: begin
					lead = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h80, 8'hC1))
						: 8'($urandom_range(8'hF5, 8'hFF));
					str_bytes.insert($urandom_range(0, str_bytes.size()), lead);
				end
			endcase
		end
	endfunction

	// Called just after a falling edge; returns just after the falling edge that follows
	// the accepting rising edge.
	task automatic send_byte(input logic [7:0] b, input logic last, input logic known,
		input text_res_t res);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			src_ch.valid <= 1'b0;
			@(negedge clk);
		end
		src_ch.valid       <= 1'b1;
		src_ch.in_byte     <= b;
		src_ch.string_last <= last;
		row_known = known;
		row_res   = res;
		do
			@(posedge clk);
		while (!src_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct);
		int target;
		int i;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		target = items_sent + PHASE_ITEMS;
		while (items_sent < target) begin
			build_string();
			for (i = 0; i < str_bytes.size(); i++)
				send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, NO_RES);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off to back the block up.
	initial begin
		int n;
		dst_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				dst_ch.ready <= 1'b0;
				for (n = 1; n < LONG_HOLD; n++)
					@(negedge clk);
				long_hold = 1'b0;
			end else begin
				dst_ch.ready <= ($urandom_range(0, 99) < rx_stall_pct) ? 1'b0 : 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check
		text_res_t got;
		text_res_t want;
		if (arst_n) begin
			if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (src_ch.valid && src_ch.ready) begin
				escape_utf8_byte(src_ch.in_byte, src_ch.string_last);
				if (row_known) begin
					expected_text.push_back(row_res);
				end else begin
					foreach (scratch[k])
						expected_text.push_back(scratch[k]);
				end
			end
			if (dst_ch.valid && dst_ch.ready) begin
				got = '{dst_ch.out_byte, dst_ch.run_end, dst_ch.string_end, dst_ch.bad_utf8};
				if (expected_text.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result: byte %02h run_end %0b string_end %0b bad %0b",
							got.text, got.run_end, got.string_end, got.bad);
				end else begin
					want = expected_text.pop_front();
					if (got.text !== want.text || got.run_end !== want.run_end ||
						got.string_end !== want.string_end || got.bad !== want.bad) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("mismatch: want %02h %0b %0b %0b, got %02h %0b %0b %0b",
								want.text, want.run_end, want.string_end, want.bad,
								got.text, got.run_end, got.string_end, got.bad);
					end
				end
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int row;
		arst_n             = 1'b0;
		src_ch.valid       = 1'b0;
		src_ch.in_byte     = 8'h00;
		src_ch.string_last = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (row = 0; row < DIRECTED_ROWS; row++)
			send_byte(DIRECTED[row].in_byte, DIRECTED[row].last, DIRECTED[row].known,
				DIRECTED[row].res);
		long_hold = 1'b1;
		run_phase(0, 0);
		run_phase(68, 0);
		run_phase(0, 68);
		run_phase(13, 13);
		src_ch.valid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### json_string_escape_encoder.f
rtl/jse_pkg.sv
rtl/jse_in_if.sv
rtl/jse_out_if.sv
rtl/jse_front.sv
rtl/jse_fifo.sv
rtl/jse_back.sv
rtl/json_string_escape_encoder.sv
verif/tb_json_string_escape_encoder.sv
